// ===== rtl/ptes_pkg.sv =====
// package for the panel toggle/encoder scanner
// holds the request and result types, operation codes, host read slots and decoder constants
// no dependencies
package ptes_pkg;

  typedef enum logic [2:0] {
    OP_PIN_CHANGE = 3'd0,
    OP_SETTLE     = 3'd1,
    OP_ENC_SAMPLE = 3'd2,
    OP_POT_SAMPLE = 3'd3,
    OP_READ_START = 3'd4,
    OP_READ_NEXT  = 3'd5
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] step_switches;
    logic       page_button;
    logic       encoder_button;
    logic [1:0] quad_first;
    logic [1:0] quad_second;
    logic       pot_index;
    logic [7:0] pot_value;
  } in_req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_error;
    logic [7:0] step_display;
    logic       page_shown;
    logic       encoder_toggle;
    logic [7:0] encoder_position;
  } out_req_t;

  // host read slots, in read order
  localparam logic [2:0] SLOT_PAGE0  = 3'd0;
  localparam logic [2:0] SLOT_PAGE1  = 3'd1;
  localparam logic [2:0] SLOT_POT0   = 3'd2;
  localparam logic [2:0] SLOT_POT1   = 3'd3;
  localparam logic [2:0] SLOT_COUNT  = 3'd4;
  localparam logic [2:0] SLOT_BUTTON = 3'd5;
  localparam logic [2:0] READ_BYTES  = 3'd6;

  // quadrature history patterns that count a detent
  localparam logic [3:0] QUAD_CW_A  = 4'b0001;
  localparam logic [3:0] QUAD_CW_B  = 4'b1110;
  localparam logic [3:0] QUAD_CCW_A = 4'b0010;
  localparam logic [3:0] QUAD_CCW_B = 4'b1101;

endpackage

// ===== rtl/panel_toggle_encoder_scanner.sv =====
// top level of the front-panel scanner: debounced toggles, pot store, host read
// depends on ptes_pkg and ptes_quad
//
// One request enters per clock while in_stall is low. A request is captured
// in an input register, applied to the panel state as it advances, and its
// result held in an output register. Every request gives exactly one result.
// The input register keeps taking requests while a finished result waits,
// and in_stall rises only when both registers are full and out_stall is
// high. There is no clearing pass after reset.
module panel_toggle_encoder_scanner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ptes_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ptes_pkg::out_req_t  out_data
);
  import ptes_pkg::*;

  // pipeline control
  logic     req_valid_r;
  in_req_t  req_r;
  logic     out_valid_r;
  out_req_t out_data_r, out_data_nxt;
  logic     advance;
  logic     take;

  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  // panel state
  logic [7:0] pattern_r [2];
  logic [7:0] pattern_nxt [2];
  logic       page_sel_r, page_sel_nxt;
  logic       btn_toggle_r, btn_toggle_nxt;
  logic [7:0] snap_steps_r, snap_steps_nxt;
  logic       snap_page_r, snap_page_nxt;
  logic       snap_button_r, snap_button_nxt;
  logic       settling_r, settling_nxt;
  logic [7:0] pot_r [2];
  logic [7:0] pot_nxt [2];
  logic [2:0] read_ptr_r, read_ptr_nxt;
  logic [7:0] shown_r, shown_nxt;
  logic [7:0] rbyte;
  logic       rerr;
  logic [7:0] position;
  logic       enc_en;

  function automatic logic [7:0] host_byte(
    input logic [2:0] slot,
    input logic [7:0] pat0,
    input logic [7:0] pat1,
    input logic [7:0] pot0,
    input logic [7:0] pot1,
    input logic [7:0] count,
    input logic       toggle
  );
    logic [7:0] b;
    case (slot)
      SLOT_PAGE0:  b = pat0;
      SLOT_PAGE1:  b = pat1;
      SLOT_POT0:   b = pot0;
      SLOT_POT1:   b = pot1;
      SLOT_COUNT:  b = count;
      SLOT_BUTTON: b = {7'd0, toggle};
      default:     b = 8'd0;
    endcase
    return b;
  endfunction

  assign enc_en = advance && (req_r.operation == OP_ENC_SAMPLE);

  ptes_quad u_quad (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_en   (enc_en),
    .quad_first  (req_r.quad_first),
    .quad_second (req_r.quad_second),
    .position    (position)
  );

  always_comb begin
    pattern_nxt     = pattern_r;
    page_sel_nxt    = page_sel_r;
    btn_toggle_nxt  = btn_toggle_r;
    snap_steps_nxt  = snap_steps_r;
    snap_page_nxt   = snap_page_r;
    snap_button_nxt = snap_button_r;
    settling_nxt    = settling_r;
    pot_nxt         = pot_r;
    read_ptr_nxt    = read_ptr_r;
    shown_nxt       = shown_r;
    rbyte           = 8'd0;
    rerr            = 1'b0;
    if (advance) begin
      case (req_r.operation)
        OP_PIN_CHANGE: begin
          if (!settling_r) begin
            snap_steps_nxt  = req_r.step_switches;
            snap_page_nxt   = req_r.page_button;
            snap_button_nxt = req_r.encoder_button;
            settling_nxt    = 1'b1;
          end
        end
        OP_SETTLE: begin
          if (settling_r) begin
            if (snap_page_r == req_r.page_button) begin
              page_sel_nxt = page_sel_r ^ snap_page_r;
            end
            // pattern toggle uses the page selected after this tick
            if (snap_steps_r == req_r.step_switches) begin
              pattern_nxt[page_sel_nxt] = pattern_r[page_sel_nxt] ^ snap_steps_r;
              shown_nxt                 = pattern_r[page_sel_nxt] ^ snap_steps_r;
            end
            if (snap_button_r == req_r.encoder_button) begin
              btn_toggle_nxt = btn_toggle_r ^ snap_button_r;
            end
            settling_nxt = 1'b0;
          end
        end
        OP_ENC_SAMPLE: begin
          // handled in the decoder
        end
        OP_POT_SAMPLE: begin
          pot_nxt[req_r.pot_index] = req_r.pot_value;
        end
        OP_READ_START: begin
          rbyte = host_byte(SLOT_PAGE0, pattern_r[0], pattern_r[1], pot_r[0], pot_r[1],
                            position, btn_toggle_r);
          read_ptr_nxt = 3'd1;
        end
        OP_READ_NEXT: begin
          if (read_ptr_r < READ_BYTES) begin
            rbyte = host_byte(read_ptr_r, pattern_r[0], pattern_r[1], pot_r[0], pot_r[1],
                              position, btn_toggle_r);
            read_ptr_nxt = read_ptr_r + 3'd1;
          end else begin
            rerr         = 1'b1;
            read_ptr_nxt = READ_BYTES;
          end
        end
        default: begin
        end
      endcase
    end
    out_data_nxt.read_byte        = rbyte;
    out_data_nxt.read_error       = rerr;
    out_data_nxt.step_display     = shown_nxt;
    out_data_nxt.page_shown       = page_sel_nxt;
    out_data_nxt.encoder_toggle   = btn_toggle_nxt;
    out_data_nxt.encoder_position = position;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      pattern_r[0]  <= '0;
      pattern_r[1]  <= '0;
      page_sel_r    <= 1'b0;
      btn_toggle_r  <= 1'b0;
      snap_steps_r  <= '0;
      snap_page_r   <= 1'b0;
      snap_button_r <= 1'b0;
      settling_r    <= 1'b0;
      pot_r[0]      <= '0;
      pot_r[1]      <= '0;
      read_ptr_r    <= '0;
      shown_r       <= '0;
    end else begin
      if (take) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      pattern_r     <= pattern_nxt;
      page_sel_r    <= page_sel_nxt;
      btn_toggle_r  <= btn_toggle_nxt;
      snap_steps_r  <= snap_steps_nxt;
      snap_page_r   <= snap_page_nxt;
      snap_button_r <= snap_button_nxt;
      settling_r    <= settling_nxt;
      pot_r         <= pot_nxt;
      read_ptr_r    <= read_ptr_nxt;
      shown_r       <= shown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/ptes_quad.sv =====
// quadrature decoder: 4-bit level history and wrapping 8-bit detent count
// uses ptes_pkg for the history patterns
module ptes_quad (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       sample_en,
  input  logic [1:0] quad_first,
  input  logic [1:0] quad_second,
  output logic [7:0] position
);
  import ptes_pkg::*;

  logic [3:0] history_r, history_nxt;
  logic [7:0] count_r, count_nxt;

  always_comb begin
    history_nxt = history_r;
    count_nxt   = count_r;
    // only a reading that agrees on both samples moves the history
    if (sample_en && (quad_first == quad_second)) begin
      history_nxt = {history_r[1:0], quad_first};
      if (history_nxt inside {QUAD_CW_A, QUAD_CW_B}) begin
        count_nxt = count_r + 8'd1;
      end else if (history_nxt inside {QUAD_CCW_A, QUAD_CCW_B}) begin
        count_nxt = count_r - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r <= '0;
      count_r   <= '0;
    end else begin
      history_r <= history_nxt;
      count_r   <= count_nxt;
    end
  end

  assign position = count_nxt;

endmodule
